// File: hw/rtl/spq_pkg.sv
// Shared constants, types and codes of the stable minimum priority queue.
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int ID_W          = 16;
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  typedef logic [ID_W-1:0]          id_t;
  typedef logic [PRIORITY_BITS-1:0] prio_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } st_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE
  } cmd_e;

  // Entry of the priority-sorted chain; age is its place in arrival order.
  typedef struct packed {
    id_t   id;
    prio_t pr;
    idx_t  age;
  } sort_data_t;

  // Entry of the arrival-ordered chain.
  typedef struct packed {
    id_t   id;
    prio_t pr;
  } arr_data_t;

  // Command broadcast to every cell in the execute cycle.
  typedef struct packed {
    cmd_e  kind;
    id_t   id;
    prio_t pr;
    cnt_t  count;
    idx_t  new_age;
    idx_t  head_age;
  } cell_cmd_t;

endpackage

// File: hw/rtl/spq_if.sv
// Request and response channel interfaces of the priority queue.
interface spq_req_if;
  import spq_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] op;
  id_t        ticket_id;
  logic [7:0] priority_req;

  modport source (output valid, output op, output ticket_id, output priority_req,
                  input ready);
  modport sink (input valid, input op, input ticket_id, input priority_req,
                output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  id_t        result_id;
  logic [7:0] result_priority;
  logic [4:0] entry_count;

  modport source (output valid, output status, output result_id,
                  output result_priority, output entry_count, input ready);
  modport sink (input valid, input status, input result_id,
                input result_priority, input entry_count, output ready);
endinterface

// File: hw/rtl/spq_sort_cell.sv
// One cell of the priority-sorted chain: shifts right on insert, left on removal.
module spq_sort_cell (
  input  logic                   clk_i,
  input  spq_pkg::cell_cmd_t     cmd_i,
  input  spq_pkg::idx_t          idx_i,
  input  spq_pkg::sort_data_t    left_i,
  input  logic                   go_left_i,
  input  spq_pkg::sort_data_t    right_i,
  output spq_pkg::sort_data_t    data_o,
  output logic                   go_o
);
  import spq_pkg::*;

  sort_data_t data_q, data_d;
  logic       live;

  assign live = (CNT_W'(idx_i) < cmd_i.count);
  // A new ticket goes in front of every strictly less urgent one, behind equals.
  assign go_o = !live || (cmd_i.pr < data_q.pr);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    case (cmd_i.kind)
      CMD_INSERT: begin
        if (go_o) begin
          if (go_left_i) begin
            data_d = left_i;
          end else begin
            data_d.id  = cmd_i.id;
            data_d.pr  = cmd_i.pr;
            data_d.age = cmd_i.new_age;
          end
        end
      end
      CMD_REMOVE: begin
        data_d = right_i;
        // Arrival places behind the removed ticket move up by one.
        if (right_i.age > cmd_i.head_age) begin
          data_d.age = right_i.age - idx_t'(1);
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: hw/rtl/spq_arr_cell.sv
// One cell of the arrival-ordered chain, with its link of the first-match search.
module spq_arr_cell (
  input  logic                 clk_i,
  input  spq_pkg::cell_cmd_t   cmd_i,
  input  spq_pkg::idx_t        idx_i,
  input  spq_pkg::arr_data_t   right_i,
  output spq_pkg::arr_data_t   data_o,
  input  logic                 hit_i,
  input  spq_pkg::arr_data_t   found_i,
  output logic                 hit_o,
  output spq_pkg::arr_data_t   found_o
);
  import spq_pkg::*;

  arr_data_t data_q, data_d;
  logic      live;
  logic      match;

  assign live  = (CNT_W'(idx_i) < cmd_i.count);
  assign match = live && (data_q.id == cmd_i.id);
  assign hit_o = hit_i || match;
  // Only the earliest matching cell drives the found data.
  assign found_o = (match && !hit_i) ? data_q : found_i;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    case (cmd_i.kind)
      CMD_INSERT: begin
        if (CNT_W'(idx_i) == cmd_i.count) begin
          data_d.id = cmd_i.id;
          data_d.pr = cmd_i.pr;
        end
      end
      CMD_REMOVE: begin
        if (idx_i >= cmd_i.head_age) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: hw/rtl/stable_min_priority_queue.sv
// Top level of the stable minimum priority queue: request stage, cell chains, result register.
//
//   channel  direction  carries
//   req_i    in         op, ticket_id, priority_req
//   rsp_o    out        status, result_id, result_priority, entry_count
//
// An item is latched at the edge it is accepted and executed once the result
// register is free or being taken, where both cell chains update and the result
// is registered; one item per cycle while results are taken at once.
// The single result register holds a result until taken; a request waiting
// behind it stalls req_i. Reset empties the queue; stored tickets need no clearing.
module stable_min_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  logic      req_vld_q;
  op_e       op_q;
  id_t       id_q;
  prio_t     pr_q;

  cnt_t      cnt_q, cnt_d;
  logic      rsp_vld_q;
  st_e       st_q, st_d;
  id_t       rid_q, rid_d;
  prio_t     rpr_q, rpr_d;

  logic      exec;
  cell_cmd_t cmd;

  sort_data_t sort_dat [CAPACITY];
  logic       sort_go  [CAPACITY];
  logic       hit_c    [CAPACITY+1];
  arr_data_t  found_c  [CAPACITY+1];
  arr_data_t  arr_dat  [CAPACITY];

  assign exec        = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      req_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      op_q <= op_e'(req_i.op);
      id_q <= req_i.ticket_id;
      pr_q <= PRIORITY_BITS'(req_i.priority_req);
    end
  end

  always_comb begin
    cmd.kind     = CMD_HOLD;
    cmd.id       = id_q;
    cmd.pr       = pr_q;
    cmd.count    = cnt_q;
    cmd.new_age  = IDX_W'(cnt_q);
    cmd.head_age = sort_dat[0].age;
    cnt_d        = cnt_q;
    st_d         = ST_OK;
    rid_d        = '0;
    rpr_d        = '0;
    if (req_vld_q) begin
      case (op_q)
        OP_ENQ: begin
          if (cnt_q == CNT_W'(CAPACITY)) begin
            st_d = ST_FULL;
          end else begin
            cmd.kind = CMD_INSERT;
            cnt_d    = cnt_q + cnt_t'(1);
          end
        end
        OP_DEQ: begin
          if (cnt_q == '0) begin
            st_d = ST_EMPTY;
          end else begin
            cmd.kind = CMD_REMOVE;
            cnt_d    = cnt_q - cnt_t'(1);
            rid_d    = sort_dat[0].id;
            rpr_d    = sort_dat[0].pr;
          end
        end
        OP_SEARCH: begin
          if (hit_c[CAPACITY]) begin
            rid_d = found_c[CAPACITY].id;
            rpr_d = found_c[CAPACITY].pr;
          end else begin
            st_d = ST_NOT_FOUND;
          end
        end
        default: st_d = ST_OK;
      endcase
    end
    // The cells see no command unless the item really executes this cycle.
    if (!exec) begin
      cmd.kind = CMD_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (exec) begin
        cnt_q     <= cnt_d;
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      st_q  <= st_d;
      rid_q <= rid_d;
      rpr_q <= rpr_d;
    end
  end

  logic [CNT_W-1:0] cnt_rsp_q;

  always_ff @(posedge clk_i) begin
    if (exec) begin
      cnt_rsp_q <= cnt_d;
    end
  end

  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.status          = st_q;
  assign rsp_o.result_id       = rid_q;
  assign rsp_o.result_priority = 8'(rpr_q);
  assign rsp_o.entry_count     = 5'(cnt_rsp_q);

  assign hit_c[0]   = 1'b0;
  assign found_c[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sort_data_t sort_left, sort_right;
    logic       go_left;
    arr_data_t  arr_right;

    if (i == 0) begin : g_first
      assign sort_left = '0;
      assign go_left   = 1'b0;
    end else begin : g_inner
      assign sort_left = sort_dat[i-1];
      assign go_left   = sort_go[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign sort_right = '0;
      assign arr_right  = '0;
    end else begin : g_mid
      assign sort_right = sort_dat[i+1];
      assign arr_right  = arr_dat[i+1];
    end

    spq_sort_cell u_sort (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .idx_i     (IDX_W'(i)),
      .left_i    (sort_left),
      .go_left_i (go_left),
      .right_i   (sort_right),
      .data_o    (sort_dat[i]),
      .go_o      (sort_go[i])
    );

    spq_arr_cell u_arr (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(i)),
      .right_i (arr_right),
      .data_o  (arr_dat[i]),
      .hit_i   (hit_c[i]),
      .found_i (found_c[i]),
      .hit_o   (hit_c[i+1]),
      .found_o (found_c[i+1])
    );
  end

endmodule
